// ----- rtl/assert_macros.svh -----
// assertion macros used by the priority ready queue controller
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PRQ_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PRQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/prq_pkg.sv -----
// shared constants, types and helper functions for the priority ready queue
// no dependencies
package prq_pkg;

	localparam int QUEUE_DEPTH   = 64;
	localparam int PRIORITY_BITS = 8;
	localparam int ID_W          = 8;
	localparam int PRIO_FIELD_W  = 8;
	localparam int STATUS_W      = 2;
	// priority bits actually kept, never more than the field carries
	localparam int PRIO_W = (PRIORITY_BITS < PRIO_FIELD_W) ? PRIORITY_BITS : PRIO_FIELD_W;
	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(QUEUE_DEPTH - 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_WALK,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic                load;
		logic                from_mem;
		logic [ID_W-1:0]     id;
		logic [STATUS_W-1:0] status;
	} res_ld_t;

	function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
		return (a == ADDR_LAST) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_dec(input logic [ADDR_W-1:0] a);
		return (a == '0) ? ADDR_LAST : a - 1'b1;
	endfunction

	// (a + off) modulo depth, with off below the depth
	function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

endpackage

// ----- rtl/prq_cmd_if.sv -----
// handshake channels of the priority ready queue: command in, result out
// depends on prq_pkg
interface prq_cmd_if;
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic [prq_pkg::ID_W-1:0]          proc_id;
	logic [prq_pkg::PRIO_FIELD_W-1:0]  priority_req;

	modport source (output valid, operation, proc_id, priority_req, input ready);
	modport sink   (input valid, operation, proc_id, priority_req, output ready);
endinterface

interface prq_res_if;
	logic                          valid;
	logic                          ready;
	logic [prq_pkg::ID_W-1:0]      result_id;
	logic [prq_pkg::STATUS_W-1:0]  status;

	modport source (output valid, result_id, status, input ready);
	modport sink   (input valid, result_id, status, output ready);
endinterface

// ----- rtl/prq_store.sv -----
// entry memory of the priority ready queue: one write and one read port,
// read data registered; depends on prq_pkg
module prq_store (
	input  logic              clk,
	input  prq_pkg::mem_wr_t  wr,
	input  prq_pkg::mem_rd_t  rd,
	output prq_pkg::entry_t   rd_data
);

	prq_pkg::entry_t mem [prq_pkg::QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ----- rtl/prq_ctrl.sv -----
// sequencer of the priority ready queue: ring pointers, insertion walk
// from the tail and head removal; depends on prq_pkg and assert_macros.svh
`include "assert_macros.svh"

module prq_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  logic                               operation,
	input  logic [prq_pkg::ID_W-1:0]           proc_id,
	input  logic [prq_pkg::PRIO_FIELD_W-1:0]   priority_req,
	input  logic                               out_free,
	input  prq_pkg::entry_t                    rd_data,
	output prq_pkg::mem_wr_t                   mem_wr,
	output prq_pkg::mem_rd_t                   mem_rd,
	output prq_pkg::res_ld_t                   res_ld
);

	prq_pkg::state_t                 state_q, state_d;
	logic [prq_pkg::ADDR_W-1:0]      head_q;
	logic [prq_pkg::CNT_W-1:0]       count_q;
	logic [prq_pkg::ADDR_W-1:0]      cur_q;
	logic [prq_pkg::CNT_W-1:0]       remain_q;
	prq_pkg::entry_t                 new_q;

	logic                            accept;
	logic                            is_full;
	logic                            is_empty;
	logic                            shift;
	logic [prq_pkg::ADDR_W-1:0]      tail_last;
	prq_pkg::entry_t                 in_entry;

	assign cmd_ready = (state_q == prq_pkg::ST_IDLE) && out_free;
	assign accept    = cmd_valid && cmd_ready;
	assign is_full   = (count_q == prq_pkg::DEPTH_CNT);
	assign is_empty  = (count_q == '0);
	assign tail_last = prq_pkg::addr_add(head_q, count_q - 1'b1);
	assign in_entry  = '{id: proc_id, prio: priority_req[prq_pkg::PRIO_W-1:0]};
	// the entry just read moves one slot towards the tail if its priority is <= the new one
	assign shift     = (rd_data.prio <= new_q.prio);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			prq_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == prq_pkg::OP_REMOVE) begin
						if (!is_empty) state_d = prq_pkg::ST_RD;
					end else if (!is_full && !is_empty) begin
						state_d = prq_pkg::ST_WALK;
					end
				end
			end
			prq_pkg::ST_RD:   state_d = prq_pkg::ST_IDLE;
			prq_pkg::ST_WALK: begin
				if (!shift) begin
					state_d = prq_pkg::ST_IDLE;
				end else if (remain_q == '0) begin
					state_d = prq_pkg::ST_PUT;
				end
			end
			prq_pkg::ST_PUT:  state_d = prq_pkg::ST_IDLE;
			default:          state_d = prq_pkg::ST_IDLE;
		endcase
	end

	// memory accesses and result loads
	always_comb begin
		mem_wr = '0;
		mem_rd = '0;
		res_ld = '0;
		case (state_q)
			prq_pkg::ST_IDLE: begin
				if (accept) begin
					res_ld.load = 1'b1;
					if (operation == prq_pkg::OP_REMOVE) begin
						if (is_empty) begin
							res_ld.status = prq_pkg::STAT_EMPTY;
						end else begin
							res_ld.from_mem = 1'b1;
							res_ld.load     = 1'b0;
							mem_rd          = '{en: 1'b1, addr: head_q};
						end
					end else if (is_full) begin
						res_ld.status = prq_pkg::STAT_FULL;
					end else begin
						res_ld.id     = proc_id;
						res_ld.status = prq_pkg::STAT_OK;
						if (is_empty) begin
							mem_wr = '{en: 1'b1, addr: head_q, data: in_entry};
						end else begin
							mem_rd = '{en: 1'b1, addr: tail_last};
						end
					end
				end
			end
			prq_pkg::ST_RD: begin
				res_ld.load     = 1'b1;
				res_ld.from_mem = 1'b1;
				res_ld.status   = prq_pkg::STAT_OK;
			end
			prq_pkg::ST_WALK: begin
				if (shift) begin
					mem_wr = '{en: 1'b1, addr: prq_pkg::addr_inc(cur_q), data: rd_data};
					if (remain_q != '0) begin
						mem_rd = '{en: 1'b1, addr: prq_pkg::addr_dec(cur_q)};
					end
				end else begin
					mem_wr = '{en: 1'b1, addr: prq_pkg::addr_inc(cur_q), data: new_q};
				end
			end
			prq_pkg::ST_PUT: begin
				mem_wr = '{en: 1'b1, addr: cur_q, data: new_q};
			end
			default: begin
				mem_wr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prq_pkg::ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (operation == prq_pkg::OP_REMOVE) begin
					if (!is_empty) begin
						head_q  <= prq_pkg::addr_inc(head_q);
						count_q <= count_q - 1'b1;
					end
				end else if (!is_full) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q    <= in_entry;
			cur_q    <= tail_last;
			remain_q <= count_q - 1'b1;
		end else if (state_q == prq_pkg::ST_WALK && shift && remain_q != '0) begin
			cur_q    <= prq_pkg::addr_dec(cur_q);
			remain_q <= remain_q - 1'b1;
		end
	end

	`PRQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= prq_pkg::DEPTH_CNT, "entry count beyond depth")
	`PRQ_ASSERT_IMPL(a_busy_no_accept, state_q != prq_pkg::ST_IDLE, !cmd_ready, "item taken while busy")
	`PRQ_ASSERT_IMPL(a_port_clash, mem_wr.en && mem_rd.en, mem_wr.addr != mem_rd.addr, "read and write hit one entry")
	`PRQ_ASSERT_NEXT(a_remove_result, accept && operation == prq_pkg::OP_REMOVE && !is_empty, res_ld.load && res_ld.from_mem, "remove result missing")

endmodule

// ----- rtl/priority_ready_queue.sv -----
// top level of the priority ready queue: command and result channels,
// output register; depends on prq_pkg, prq_cmd_if, prq_store, prq_ctrl
//
// usage
//   cmd carries one item: operation (insert or remove), proc_id and
//   priority_req; res returns exactly one item per command: result_id and
//   status (ok, empty on remove, full on insert)
//   entries sit in a ring in one memory, sorted by descending priority from
//   the head; equal priorities put the newest first
//   sequencing, set by the single read port of the entry memory
//     insert, full or empty: result registered on acceptance
//     remove: head read, result loaded in ST_RD, no item taken until then
//     insert: busy while entries with priority <= the new one are moved,
//       one entry a cycle; not busy when the queue is empty or full
//   reset clears the count and head pointer at once; the entry memory has
//   no clearing pass, since only written slots are ever read
//   a stalled receiver holds the result in the output register; the next
//   item is taken in the same cycle the waiting result leaves
module priority_ready_queue (
	input  logic            clk,
	input  logic            arst_n,
	prq_cmd_if.sink         cmd,
	prq_res_if.source       res
);

	prq_pkg::mem_wr_t                 mem_wr;
	prq_pkg::mem_rd_t                 mem_rd;
	prq_pkg::entry_t                  rd_data;
	prq_pkg::res_ld_t                 res_ld;
	logic                             out_free;

	logic                             out_valid_q;
	logic [prq_pkg::ID_W-1:0]         out_id_q;
	logic [prq_pkg::STATUS_W-1:0]     out_status_q;

	// output register free now, or emptied at this edge
	assign out_free = !out_valid_q || res.ready;

	prq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd.valid),
		.cmd_ready    (cmd.ready),
		.operation    (cmd.operation),
		.proc_id      (cmd.proc_id),
		.priority_req (cmd.priority_req),
		.out_free     (out_free),
		.rd_data      (rd_data),
		.mem_wr       (mem_wr),
		.mem_rd       (mem_rd),
		.res_ld       (res_ld)
	);

	prq_store u_store (
		.clk     (clk),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (rd_data)
	);

	// result register: a load always finds it free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ld.load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld.load) begin
			// removed head comes straight from the memory read register
			out_id_q     <= res_ld.from_mem ? rd_data.id : res_ld.id;
			out_status_q <= res_ld.status;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.result_id = out_id_q;
	assign res.status    = out_status_q;

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the priority ready queue: directed table, then random phases
// depends on prq_pkg, prq_cmd_if, prq_res_if and priority_ready_queue
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prq_pkg::*;

	// one expected or observed result item
	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [STATUS_W-1:0] status;
	} sched_result_t;

	// one row of the directed table; fixed rows carry their answer,
	// the others take it from the scheduler model
	typedef struct packed {
		logic                op;
		logic [ID_W-1:0]     id;
		logic [PRIO_FIELD_W-1:0] prio;
		bit                  fixed;
		logic [ID_W-1:0]     exp_id;
		logic [STATUS_W-1:0] exp_status;
	} directed_row_t;

	typedef enum logic [1:0] {
		PRIO_FULL,
		PRIO_TIES,
		PRIO_EXTREME
	} prio_mode_e;

	// one random phase: how many items, share of inserts, priority spread, calm flag
	typedef struct packed {
		int unsigned items;
		int unsigned insert_pct;
		prio_mode_e  mode;
		bit          calm;
	} phase_t;

	localparam int N_DIRECTED = 21;
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		// remove straight after reset finds nothing
		'{OP_REMOVE, 8'h5A, 8'h33, 1'b1, 8'h00, STAT_EMPTY},
		// insert into an empty queue, then the extremes of id and priority
		'{OP_INSERT, 8'hFF, 8'h01, 1'b1, 8'hFF, STAT_OK},
		'{OP_INSERT, 8'h00, 8'hFF, 1'b1, 8'h00, STAT_OK},
		// equal priorities, the newer one must come out first
		'{OP_INSERT, 8'h11, 8'h80, 1'b1, 8'h11, STAT_OK},
		'{OP_INSERT, 8'h22, 8'h80, 1'b1, 8'h22, STAT_OK},
		// lowest priority present goes to the tail
		'{OP_INSERT, 8'h33, 8'h00, 1'b1, 8'h33, STAT_OK},
		// tie at the top lands at the head
		'{OP_INSERT, 8'h44, 8'hFF, 1'b1, 8'h44, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b0, 8'h00, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b0, 8'h00, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b0, 8'h00, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b0, 8'h00, STAT_OK},
		// insert ahead of everything that is left
		'{OP_INSERT, 8'hAA, 8'h7F, 1'b1, 8'hAA, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b0, 8'h00, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b0, 8'h00, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b0, 8'h00, STAT_OK},
		// drained again, and the payload of a remove is ignored
		'{OP_REMOVE, 8'hFF, 8'hFF, 1'b1, 8'h00, STAT_EMPTY},
		'{OP_INSERT, 8'h5A, 8'hA5, 1'b1, 8'h5A, STAT_OK},
		'{OP_INSERT, 8'hA5, 8'h5A, 1'b1, 8'hA5, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b0, 8'h00, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b0, 8'h00, STAT_OK},
		'{OP_REMOVE, 8'h00, 8'h00, 1'b1, 8'h00, STAT_EMPTY}
	};

	// fill past full, drain past empty, then mixed traffic with ties and extremes
	localparam int N_PHASES = 7;
	localparam phase_t PHASES [N_PHASES] = '{
		'{72,  100, PRIO_FULL,    1'b0},
		'{72,  0,   PRIO_FULL,    1'b0},
		'{150, 55,  PRIO_TIES,    1'b1},
		'{70,  90,  PRIO_TIES,    1'b0},
		'{150, 50,  PRIO_EXTREME, 1'b0},
		'{70,  5,   PRIO_FULL,    1'b0},
		'{170, 60,  PRIO_FULL,    1'b0}
	};

	// insert may walk every stored entry, plus margin
	localparam int DRAIN_CYCLES = QUEUE_DEPTH + 16;
	localparam int WAIT_LIMIT   = 4000;

	logic clk = 1'b0;
	logic arst_n;

	prq_cmd_if cmd_ch ();
	prq_res_if res_ch ();

	priority_ready_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// scheduler model: the ready list, head first
	entry_t        ready_list [$];
	sched_result_t pending_results [$];

	bit no_idle;
	int unsigned errors;
	int unsigned n_inserts, n_removes, n_full, n_empty, peak_depth;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// applies one accepted item to the ready list and gives its result
	function automatic sched_result_t schedule_step(input logic op, input logic [ID_W-1:0] id,
			input logic [PRIO_FIELD_W-1:0] prio);
		sched_result_t r;
		entry_t        e;
		int            pos;
		e.id   = id;
		e.prio = prio[PRIO_W-1:0];
		if (op == OP_INSERT) begin
			n_inserts++;
			if (ready_list.size() >= QUEUE_DEPTH) begin
				n_full++;
				r = '{'0, STAT_FULL};
			end else begin
				// ahead of the first entry with priority <= the new one
				pos = ready_list.size();
				for (int k = 0; k < ready_list.size(); k++) begin
					if (e.prio >= ready_list[k].prio) begin
						pos = k;
						break;
					end
				end
				ready_list.insert(pos, e);
				if (ready_list.size() > peak_depth) begin
					peak_depth = ready_list.size();
				end
				r = '{id, STAT_OK};
			end
		end else begin
			n_removes++;
			if (ready_list.size() == 0) begin
				n_empty++;
				r = '{'0, STAT_EMPTY};
			end else begin
				e = ready_list.pop_front();
				r = '{e.id, STAT_OK};
			end
		end
		return r;
	endfunction

	// drives one item, with a random idle gap first, and returns at the
	// edge where it is taken; valid stays high for the caller's next item
	task automatic send_item(input logic op, input logic [ID_W-1:0] id,
			input logic [PRIO_FIELD_W-1:0] prio);
		while (!no_idle && $urandom_range(0, 99) < 6) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.operation    <= op;
		cmd_ch.proc_id      <= id;
		cmd_ch.priority_req <= prio;
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
	endtask

	// holds the sender off until every expected result is back or the wait limit runs out
	task automatic wait_for_results();
		int n;
		cmd_ch.valid <= 1'b0;
		n = 0;
		while (pending_results.size() != 0 && n < WAIT_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
			pending_results.delete();
		end
	endtask

	function automatic logic [PRIO_FIELD_W-1:0] pick_prio(input prio_mode_e mode);
		logic [PRIO_FIELD_W-1:0] p;
		case (mode)
			PRIO_TIES: begin
				// a handful of values, so equal priorities pile up
				p = PRIO_FIELD_W'($urandom_range(0, 3));
			end
			PRIO_EXTREME: begin
				case ($urandom_range(0, 3))
					0: p = '0;
					1: p = '1;
					default: p = PRIO_FIELD_W'($urandom_range(0, 255));
				endcase
			end
			default: begin
				p = PRIO_FIELD_W'($urandom_range(0, 255));
			end
		endcase
		return p;
	endfunction

	// receiver: stalls now and then, never during a calm stretch
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 6);
		end
	end

	// result checker: each taken result against the oldest expectation
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result id %02h status %0d",
					res_ch.result_id, res_ch.status));
			end else begin
				want = pending_results.pop_front();
				if (res_ch.result_id !== want.id) begin
					report_mismatch($sformatf("result_id %02h, expected %02h",
						res_ch.result_id, want.id));
				end
				if (res_ch.status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %0d",
						res_ch.status, want.status));
				end
			end
		end
	end

	// stimulus: reset, directed table, random phases, drain and verdict
	initial begin
		sched_result_t           exp;
		logic                    op;
		logic [PRIO_FIELD_W-1:0] prio;
		int unsigned             n_random;

		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.operation    = OP_INSERT;
		cmd_ch.proc_id      = '0;
		cmd_ch.priority_req = '0;
		no_idle             = 1'b0;
		errors              = 0;
		n_random            = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_item(DIRECTED[i].op, DIRECTED[i].id, DIRECTED[i].prio);
			exp = schedule_step(DIRECTED[i].op, DIRECTED[i].id, DIRECTED[i].prio);
			if (DIRECTED[i].fixed) begin
				exp = '{DIRECTED[i].exp_id, DIRECTED[i].exp_status};
			end
			pending_results.push_back(exp);
		end
		wait_for_results();

		// random phases, each ending with the sender held off until all is back
		for (int p = 0; p < N_PHASES; p++) begin
			no_idle = PHASES[p].calm;
			for (int unsigned k = 0; k < PHASES[p].items; k++) begin
				op   = ($urandom_range(0, 99) < PHASES[p].insert_pct) ? OP_INSERT : OP_REMOVE;
				prio = pick_prio(PHASES[p].mode);
				send_item(op, ID_W'($urandom_range(0, 255)), prio);
				pending_results.push_back(schedule_step(op, cmd_ch.proc_id, prio));
				n_random++;
			end
			no_idle = 1'b0;
			wait_for_results();
		end

		// let any late or spurious result show itself
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d directed and %0d random items, %0d inserts (%0d full), %0d removes (%0d empty)",
			N_DIRECTED, n_random, n_inserts, n_full, n_removes, n_empty);
		$display("summary: peak depth %0d of %0d, %0d mismatches", peak_depth, QUEUE_DEPTH, errors);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_cmd_if.sv
rtl/prq_store.sv
rtl/prq_ctrl.sv
rtl/priority_ready_queue.sv
dv/tb.sv
